### sv/rhcl_pkg.sv
// shared definitions for the rgb to hue / chroma / lightness unit
// default widths, sextant base codes and the sextant offset decoder; no dependencies
package rhcl_pkg;

    localparam int CHANNEL_BITS_DEF      = 8;
    localparam int HUE_FRACTION_BITS_DEF = 8;
    localparam int BASE_BITS             = 2;
    localparam int OFFSET_BITS           = 3;

    // channel holding the maximum, red split by the sign of green minus blue
    typedef enum logic [BASE_BITS-1:0] {
        BASE_RED_LOW  = 2'd0,
        BASE_GREEN    = 2'd1,
        BASE_BLUE     = 2'd2,
        BASE_RED_HIGH = 2'd3
    } t_base;

    // base minus one sextant, modulo eight sextants
    function automatic logic [OFFSET_BITS-1:0] hue_offset(input t_base base);
        logic [OFFSET_BITS-1:0] off;
        unique case (base)
            BASE_RED_LOW:  off = 3'd7;
            BASE_GREEN:    off = 3'd1;
            BASE_BLUE:     off = 3'd3;
            BASE_RED_HIGH: off = 3'd5;
            default:       off = 3'd0;
        endcase
        return off;
    endfunction

endpackage

### sv/rhcl_pix_if.sv
// pixel input channel: valid / ready handshake with red, green and blue
// depends on rhcl_pkg for the default channel width
interface rhcl_pix_if
    import rhcl_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### sv/rhcl_hcl_if.sv
// result channel: valid / ready handshake with hue, chroma, lightness and gray flag
// depends on rhcl_pkg for the default widths
interface rhcl_hcl_if
    import rhcl_pkg::*;
#(
    parameter int CHANNEL_BITS      = CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = HUE_FRACTION_BITS_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic [HUE_FRACTION_BITS+2:0]   hue;
    logic [CHANNEL_BITS-1:0]        chroma;
    logic [CHANNEL_BITS:0]          lightness_twice;
    logic                           is_gray;

    modport source (output valid, output hue, output chroma, output lightness_twice,
                    output is_gray, input ready);
    modport sink   (input valid, input hue, input chroma, input lightness_twice,
                    input is_gray, output ready);
endinterface

### sv/rhcl_div.sv
// pipelined restoring divider, one quotient bit per register stage
// carries divisor and a side payload along with each beat; no dependencies
module rhcl_div #(
    parameter int W      = 8,
    parameter int QB     = 10,
    parameter int SIDE_W = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W-1:0]      i_rem,
    input  logic [QB-1:0]     i_low,
    input  logic [W-1:0]      i_div,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QB-1:0]     o_quot,
    output logic [W-1:0]      o_div,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid [QB];
    logic [W-1:0]      r_rem   [QB];
    logic [QB-1:0]     r_low   [QB];
    logic [W-1:0]      r_div   [QB];
    logic [SIDE_W-1:0] r_side  [QB];

    genvar j;
    for (j = 0; j < QB; j++) begin : g_stage
        logic              v_in;
        logic [W-1:0]      rem_in;
        logic [QB-1:0]     low_in;
        logic [W-1:0]      div_in;
        logic [SIDE_W-1:0] side_in;
        logic [W:0]        trial;
        logic [W:0]        n_rem;
        logic [QB-1:0]     n_low;
        logic              ge;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_rem;
            assign low_in  = i_low;
            assign div_in  = i_div;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[j-1];
            assign rem_in  = r_rem[j-1];
            assign low_in  = r_low[j-1];
            assign div_in  = r_div[j-1];
            assign side_in = r_side[j-1];
        end

        // partial remainder stays below the divisor, dividend bits leave at the top
        assign trial = {rem_in, low_in[QB-1]};
        assign ge    = trial >= {1'b0, div_in};
        assign n_rem = ge ? trial - {1'b0, div_in} : trial;
        assign n_low = {low_in[QB-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem[W-1:0];
                r_low[j]  <= n_low;
                r_div[j]  <= div_in;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[QB-1];
    assign o_quot  = r_low[QB-1];
    assign o_div   = r_div[QB-1];
    assign o_side  = r_side[QB-1];

endmodule

### sv/rgb_to_hue_chroma_lightness_unit.sv
// One RGB pixel per clock in, one hue / chroma / lightness result per clock out. One
// stage finds max, min and the hue base, HUE_FRACTION_BITS + 2 divider stages each
// resolve one quotient bit of the hue fraction, and one stage adds the sextant base. Hue
// counts 2^HUE_FRACTION_BITS units per sextant, truncated; gray pixels give hue 0 with
// is_gray set. A stall on the output holds the whole pipeline, and input ready is high
// while the output register is empty or output ready is high.
// depends on rhcl_pkg, rhcl_pix_if, rhcl_hcl_if and rhcl_div
module rgb_to_hue_chroma_lightness_unit
    import rhcl_pkg::*;
#(
    parameter int CHANNEL_BITS      = CHANNEL_BITS_DEF,
    parameter int HUE_FRACTION_BITS = HUE_FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rhcl_pix_if.sink    i_pix,
    rhcl_hcl_if.source  o_hcl
);

    localparam int W      = CHANNEL_BITS;
    localparam int F      = HUE_FRACTION_BITS;
    localparam int QB     = F + 2;
    localparam int HW     = F + 3;
    localparam int SIDE_W = W + 1 + 1 + BASE_BITS;

    logic en;

    logic          r_o_valid;
    logic [HW-1:0] r_o_hue;
    logic [W-1:0]  r_o_c;
    logic [W:0]    r_o_sum;
    logic          r_o_gray;

    // stage a: max, min, base and difference operands
    logic [W-1:0] red, green, blue;
    logic         red_max, green_max;
    logic [W-1:0] mx, mn, pos, neg;
    t_base        base;

    logic         r_a_valid;
    logic [W-1:0] r_a_c;
    logic [W:0]   r_a_sum;
    t_base        r_a_base;
    logic [W-1:0] r_a_pos;
    logic [W-1:0] r_a_neg;
    logic         r_a_gray;

    assign en          = !r_o_valid || o_hcl.ready;
    assign i_pix.ready = en;

    assign red   = i_pix.red;
    assign green = i_pix.green;
    assign blue  = i_pix.blue;

    always_comb begin
        red_max   = (red >= green) && (red >= blue);
        green_max = !red_max && (green >= blue);
        if (red_max) begin
            mx   = red;
            pos  = green;
            neg  = blue;
            base = (green >= blue) ? BASE_RED_LOW : BASE_RED_HIGH;
        end else if (green_max) begin
            mx   = green;
            pos  = blue;
            neg  = red;
            base = BASE_GREEN;
        end else begin
            mx   = blue;
            pos  = red;
            neg  = green;
            base = BASE_BLUE;
        end
        if ((red <= green) && (red <= blue)) begin
            mn = red;
        end else if (green <= blue) begin
            mn = green;
        end else begin
            mn = blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_c    <= mx - mn;
            r_a_sum  <= {1'b0, mx} + {1'b0, mn};
            r_a_base <= base;
            r_a_pos  <= pos;
            r_a_neg  <= neg;
            r_a_gray <= (mx == mn);
        end
    end

    // difference plus chroma lies in 0..2c, so its top bits start below the divisor
    logic [W:0]        shifted;
    logic [W-1:0]      div_rem;
    logic [QB-1:0]     div_low;
    logic [SIDE_W-1:0] div_side;

    assign shifted  = {1'b0, r_a_pos} + {1'b0, r_a_c} - {1'b0, r_a_neg};
    assign div_rem  = {1'b0, shifted[W:2]};
    assign div_low  = {shifted[1:0], {F{1'b0}}};
    assign div_side = {r_a_sum, r_a_gray, r_a_base};

    logic              q_valid;
    logic [QB-1:0]     q_quot;
    logic [W-1:0]      q_c;
    logic [SIDE_W-1:0] q_side;

    rhcl_div #(
        .W      (W),
        .QB     (QB),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_valid),
        .i_rem   (div_rem),
        .i_low   (div_low),
        .i_div   (r_a_c),
        .i_side  (div_side),
        .o_valid (q_valid),
        .o_quot  (q_quot),
        .o_div   (q_c),
        .o_side  (q_side)
    );

    // output stage: add sextant base, wrap modulo eight sextants, force hue 0 for gray
    logic [W:0]    q_sum;
    logic          q_gray;
    t_base         q_base;
    logic [HW-1:0] hue_sum;

    assign q_sum   = q_side[SIDE_W-1 -: W+1];
    assign q_gray  = q_side[BASE_BITS];
    assign q_base  = t_base'(q_side[BASE_BITS-1:0]);
    assign hue_sum = {1'b0, q_quot} + {hue_offset(q_base), {F{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_hue  <= q_gray ? '0 : hue_sum;
            r_o_c    <= q_c;
            r_o_sum  <= q_sum;
            r_o_gray <= q_gray;
        end
    end

    assign o_hcl.valid           = r_o_valid;
    assign o_hcl.hue             = r_o_hue;
    assign o_hcl.chroma          = r_o_c;
    assign o_hcl.lightness_twice = r_o_sum;
    assign o_hcl.is_gray         = r_o_gray;

endmodule
